// ===== hw/rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, request and status codes and the result word type of the
// bounded double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST       = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [STAT_W-1:0]        status;
    logic                     last_of_run;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdq_req_if.sv =====
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: valid/ready handshake carrying one request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_req_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bdq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_rsp_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic [STAT_W-1:0]        status;
  logic                     last_of_run;

  modport source (output valid, output out_value, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_value, input status, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [IDX_W-1:0]                 wr_addr,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] wr_data,
  input  wire logic                             rd_en,
  input  wire logic [IDX_W-1:0]                 rd_addr,
  output logic signed [bdq_pkg::DATA_W-1:0]     rd_data
);
  import bdq_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

`default_nettype wire

// ===== hw/rtl/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request decode, ring pointers, memory sequencing and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bdq_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] in_item_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bdq_pkg::rsp_t                          out_rsp,
  output logic                                   wr_en,
  output logic [IDX_W-1:0]                       wr_addr,
  output logic signed [bdq_pkg::DATA_W-1:0]      wr_data,
  output logic                                   rd_en,
  output logic [IDX_W-1:0]                       rd_addr,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] rd_data
);
  import bdq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] s);
    logic [IDX_W:0] t;
    t = (s >= DEPTH_X) ? (s - DEPTH_X) : s;
    return t[IDX_W-1:0];
  endfunction

  logic             state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] end_k_r, end_k_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             rsp_r, rsp_nxt;

  logic             out_free;
  logic             acc;
  logic [CNT_W-1:0] count_m1;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign count_m1 = count_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    end_k_nxt     = end_k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rsp_nxt       = rsp_r;
    wr_en         = 1'b0;
    wr_addr       = front_r;
    wr_data       = in_item_value;
    rd_en         = 1'b0;
    rd_addr       = front_r;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (count_r == FULL_CNT) begin
                rsp_nxt = '{out_value: '0, status: ST_FULL, last_of_run: 1'b1};
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + 1'b1;
                rsp_nxt   = '{out_value: '0, status: ST_DONE, last_of_run: 1'b1};
                if (in_req_type == REQ_PUSH_FRONT) begin
                  wr_addr   = (front_r == '0) ? LAST_IDX : (front_r - 1'b1);
                  front_nxt = wr_addr;
                end else begin
                  wr_addr = wrap_idx({1'b0, front_r} + {1'b0, count_r[IDX_W-1:0]});
                end
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK, REQ_LIST: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                rsp_nxt = '{out_value: '0, status: ST_EMPTY, last_of_run: 1'b1};
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_RD;
                k_nxt     = '0;
                end_k_nxt = '0;
                if (in_req_type == REQ_POP_FRONT) begin
                  rd_addr   = front_r;
                  front_nxt = wrap_idx({1'b0, front_r} + 1'b1);
                  count_nxt = count_m1;
                end else if (in_req_type == REQ_POP_BACK) begin
                  rd_addr   = wrap_idx({1'b0, front_r} + {1'b0, count_m1[IDX_W-1:0]});
                  count_nxt = count_m1;
                end else begin
                  rd_addr   = front_r;
                  end_k_nxt = count_m1[IDX_W-1:0];
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          rsp_nxt = '{out_value: rd_data, status: ST_DONE, last_of_run: (k_r == end_k_r)};
          if (k_r != end_k_r) begin
            k_nxt   = k_r + 1'b1;
            rd_en   = 1'b1;
            rd_addr = wrap_idx({1'b0, front_r} + {1'b0, k_nxt});
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      k_r         <= '0;
      end_k_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      end_k_r     <= end_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;
endmodule

`default_nettype wire

// ===== hw/rtl/bounded_double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Double-ended queue of DEPTH words held in a ring memory.
// ----------------------------------------------------------------------------
//   channel   dir  word
//   in_req    in   req_type, item_value
//   out_rsp   out  out_value, status, last_of_run
//
// Push: result word registered at the accepting edge.
// Pop: the ring memory registers the read data, then the result register takes it.
// List: one memory read per entry on the single read port.
// Reset (rst_n low, synchronous) empties the queue; memory contents are not cleared.
// A stalled result holds its word and the memory read data until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue_unit #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  bdq_req_if.sink   in_req,
  bdq_rsp_if.source out_rsp
);
  import bdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic signed [DATA_W-1:0] rd_data;
  rsp_t                     rsp;

  bdq_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_req.valid),
    .in_ready      (in_req.ready),
    .in_req_type   (in_req.req_type),
    .in_item_value (in_req.item_value),
    .out_valid     (out_rsp.valid),
    .out_ready     (out_rsp.ready),
    .out_rsp       (rsp),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data)
  );

  bdq_ram #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_rsp.out_value   = rsp.out_value;
  assign out_rsp.status      = rsp.status;
  assign out_rsp.last_of_run = rsp.last_of_run;

  a_ready_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> (!out_rsp.valid || out_rsp.ready))
    else $error("request taken while result slot is blocked");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready &&
     (in_req.req_type == REQ_PUSH_FRONT || in_req.req_type == REQ_PUSH_BACK))
    |=> (out_rsp.valid && out_rsp.last_of_run && out_rsp.out_value == '0 &&
         (out_rsp.status == ST_DONE || out_rsp.status == ST_FULL)))
    else $error("push did not give its result word");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status != ST_DONE)
    |-> (out_rsp.last_of_run && out_rsp.out_value == '0))
    else $error("status word not marked last");

  a_no_wr_rd_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("memory write and read in the same cycle");
endmodule

`default_nettype wire

// ===== bench/bdq_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_result_checker
// Watches the request and result channels of the double-ended queue, keeps
// its own copy of the ring, the front slot and the fill level, works out the
// result words of every accepted request and compares each accepted result
// word, field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
module bdq_result_checker #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bdq_req_if        req_mon,
  bdq_rsp_if        rsp_mon,
  output int        mismatches,
  output int        pending
);
  import bdq_pkg::*;

  localparam int PRINT_LIMIT = 40;

  logic [DATA_W-1:0] ring [DEPTH];
  int                head;
  int                fill;
  rsp_t              awaited_rsp [$];

  function automatic rsp_t make_word(logic [DATA_W-1:0] value, logic [STAT_W-1:0] status,
                                     logic last);
    rsp_t w;
    w.out_value   = value;
    w.status      = status;
    w.last_of_run = last;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t ns  mismatch: %s", $time, what);
  endtask

  task automatic compute_responses(input logic [REQ_W-1:0] kind,
                                   input logic [DATA_W-1:0] value);
    int slot;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill == DEPTH) begin
          awaited_rsp.push_back(make_word('0, ST_FULL, 1'b1));
        end else begin
          if (kind == REQ_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            slot = head;
          end else begin
            slot = (head + fill) % DEPTH;
          end
          ring[slot] = value;
          fill++;
          awaited_rsp.push_back(make_word('0, ST_DONE, 1'b1));
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (fill == 0) begin
          awaited_rsp.push_back(make_word('0, ST_EMPTY, 1'b1));
        end else begin
          if (kind == REQ_POP_FRONT) begin
            slot = head;
            head = (head + 1) % DEPTH;
          end else begin
            slot = (head + fill - 1) % DEPTH;
          end
          fill--;
          awaited_rsp.push_back(make_word(ring[slot], ST_DONE, 1'b1));
        end
      end
      REQ_LIST: begin
        if (fill == 0) begin
          awaited_rsp.push_back(make_word('0, ST_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < fill; i++)
            awaited_rsp.push_back(make_word(ring[(head + i) % DEPTH], ST_DONE,
                                            i == fill - 1));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    rsp_t oldest;
    if (!rst_n) begin
      head       = 0;
      fill       = 0;
      mismatches = 0;
      awaited_rsp.delete();
    end else begin
      // match the result word first: it always belongs to an earlier request
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch($sformatf("unexpected word value=%0d status=%0d last=%0b",
                                    rsp_mon.out_value, rsp_mon.status,
                                    rsp_mon.last_of_run));
        end else begin
          oldest = awaited_rsp.pop_front();
          if (rsp_mon.out_value !== oldest.out_value || rsp_mon.status !== oldest.status ||
              rsp_mon.last_of_run !== oldest.last_of_run)
            report_mismatch($sformatf("got value=%0d status=%0d last=%0b, want %0d/%0d/%0b",
                                      rsp_mon.out_value, rsp_mon.status,
                                      rsp_mon.last_of_run, oldest.out_value,
                                      oldest.status, oldest.last_of_run));
        end
      end
      if (req_mon.valid && req_mon.ready)
        compute_responses(req_mon.req_type, req_mon.item_value);
    end
    pending <= awaited_rsp.size();
  end

endmodule

// ===== bench/tb_bounded_double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue_unit
// Drives the double-ended queue with a directed run through the empty, full
// and wrap-around cases, then with random phases that lean toward filling,
// draining or listing, with bursty requests and a stalling receiver. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_bounded_double_ended_queue_unit;
  import bdq_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 180;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
  localparam logic [REQ_W-1:0] REQ_RSVD_FIRST = REQ_LIST + 1'b1;
  localparam logic [REQ_W-1:0] REQ_RSVD_LAST  = '1;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_LIST} phase_e;

  logic clk = 1'b0;
  logic rst_n;
  int   burst_left  = 0;
  int   idle_cycles = 0;
  int   mismatches;
  int   pending;

  bdq_req_if in_req ();
  bdq_rsp_if out_rsp ();

  bounded_double_ended_queue_unit #(.DEPTH(DEPTH)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  bdq_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_req),
    .rsp_mon    (out_rsp),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_req.valid      <= 1'b1;
    in_req.req_type   <= kind;
    in_req.item_value <= value;
    do @(posedge clk); while (!in_req.ready);
  endtask

  initial begin
    int mode;
    int tick;
    out_rsp.ready = 1'b0;
    mode = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      tick++;
      case (mode)
        0:       out_rsp.ready <= 1'b1;
        1:       out_rsp.ready <= ($urandom_range(0, 4) != 0);
        2:       out_rsp.ready <= ($urandom_range(0, 1) == 1);
        default: out_rsp.ready <= ((tick % 11) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    phase_e           phase;
    int               phase_left;
    int               issued;
    int               r;
    logic [REQ_W-1:0] kind;

    rst_n             = 1'b0;
    in_req.valid      = 1'b0;
    in_req.req_type   = REQ_LIST;
    in_req.item_value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(REQ_LIST, pick_value());
    send_req(REQ_POP_FRONT, pick_value());
    send_req(REQ_PUSH_FRONT, 32'h7FFF_FFFF);
    send_req(REQ_PUSH_BACK, 32'h8000_0000);
    send_req(REQ_LIST, '0);
    send_req(REQ_POP_BACK, '1);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_BACK, pick_value());
    for (int c = REQ_RSVD_FIRST; c <= REQ_RSVD_LAST; c++) send_req(REQ_W'(c), pick_value());
    for (int i = 0; i < DEPTH; i++)
      send_req((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
    send_req(REQ_PUSH_BACK, pick_value());
    send_req(REQ_LIST, pick_value());

    issued     = 0;
    phase_left = 0;
    phase      = PH_MIXED;
    while (issued < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase      = phase_e'($urandom_range(0, 3));
        phase_left = $urandom_range(12, 30);
      end
      r = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  kind = (r < 75) ? REQ_PUSH_BACK : (r < 88) ? REQ_LIST :
                         (r < 96) ? REQ_POP_FRONT : REQ_RSVD_FIRST;
        PH_DRAIN: kind = (r < 70) ? REQ_POP_FRONT : (r < 85) ? REQ_PUSH_BACK :
                         (r < 96) ? REQ_LIST : REQ_RSVD_FIRST;
        PH_LIST:  kind = (r < 40) ? REQ_LIST : (r < 70) ? REQ_PUSH_BACK :
                         (r < 96) ? REQ_POP_FRONT : REQ_RSVD_FIRST;
        default:  kind = (r < 40) ? REQ_PUSH_BACK : (r < 75) ? REQ_POP_FRONT :
                         (r < 95) ? REQ_LIST : REQ_RSVD_FIRST;
      endcase
      // pick the end of the queue, or the spare code, at random
      if (kind == REQ_PUSH_BACK && $urandom_range(0, 1)) kind = REQ_PUSH_FRONT;
      if (kind == REQ_POP_FRONT && $urandom_range(0, 1)) kind = REQ_POP_BACK;
      if (kind == REQ_RSVD_FIRST)
        kind = REQ_W'($urandom_range(REQ_RSVD_FIRST, REQ_RSVD_LAST));
      send_req(kind, pick_value());
      if (kind <= REQ_LIST) begin
        issued++;
        phase_left--;
      end
    end
    in_req.valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== bounded_double_ended_queue_unit.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_req_if.sv
hw/rtl/bdq_rsp_if.sv
hw/rtl/bdq_ram.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bounded_double_ended_queue_unit.sv
bench/bdq_result_checker.sv
bench/tb_bounded_double_ended_queue_unit.sv
